/* rtl/xeu_pkg.sv */
// Shared types and constants of the x86 subset execute unit.
// Used by xeu_ctrl, xeu_dp and the top level.
package xeu_pkg;

  localparam int NumRegs = 18;
  localparam logic [4:0] RegAx = 5'd0;
  localparam logic [4:0] RegDx = 5'd3;
  localparam logic [4:0] RegSp = 5'd7;
  localparam logic [4:0] RegIp = 5'd16;
  localparam logic [4:0] RegFl = 5'd17;

  localparam int FlagCf = 0;
  localparam int FlagZf = 6;
  localparam int FlagSf = 7;
  localparam int FlagOf = 11;

  localparam logic [7:0] FrameTag = 8'd8;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StHalt = 3'd1;
  localparam logic [2:0] StIll = 3'd2;
  localparam logic [2:0] StDiv0 = 3'd3;
  localparam logic [2:0] StStack = 3'd4;

  localparam logic [4:0] OpCdq = 5'd2;
  localparam logic [4:0] OpAdd = 5'd3;
  localparam logic [4:0] OpSub = 5'd4;
  localparam logic [4:0] OpImul = 5'd5;
  localparam logic [4:0] OpIdiv = 5'd6;
  localparam logic [4:0] OpCmp = 5'd7;
  localparam logic [4:0] OpMov = 5'd8;
  localparam logic [4:0] OpMovzx = 5'd9;
  localparam logic [4:0] OpPush = 5'd11;
  localparam logic [4:0] OpPop = 5'd12;
  localparam logic [4:0] OpSete = 5'd13;
  localparam logic [4:0] OpSetl = 5'd14;
  localparam logic [4:0] OpSetle = 5'd15;
  localparam logic [4:0] OpSetg = 5'd16;
  localparam logic [4:0] OpSetge = 5'd17;
  localparam logic [4:0] OpSetne = 5'd18;

  localparam logic [2:0] KindImm = 3'd0;
  localparam logic [2:0] KindR64 = 3'd1;
  localparam logic [2:0] KindR32 = 3'd2;
  localparam logic [2:0] KindR16 = 3'd3;
  localparam logic [2:0] KindLow = 3'd4;
  localparam logic [2:0] KindHigh = 3'd5;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdMulStep, CmdMulDone, CmdDivInit, CmdDivStep,
    CmdStkByte, CmdCommit, CmdClear
  } dp_cmd_e_t;

  typedef struct packed {
    dp_cmd_e_t op;
    logic [3:0] idx;  // byte index of a stack frame access
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [4:0] cmd;
    logic       halted;
    logic       illegal;
    logic       div_zero;
    logic       stk_range;
    logic       tag_bad;
  } dp_stat_t;

  function automatic logic is_reg(logic [2:0] kind, logic [4:0] num);
    return kind >= KindR64 && kind <= KindHigh && num < 5'(NumRegs);
  endfunction

  function automatic logic [63:0] view_get(logic [63:0] v, logic [2:0] kind);
    unique case (kind)
      KindR64: return v;
      KindR32: return {32'd0, v[31:0]};
      KindR16: return {48'd0, v[15:0]};
      KindLow: return {56'd0, v[7:0]};
      default: return {56'd0, v[15:8]};
    endcase
  endfunction

  function automatic logic [63:0] view_put(logic [63:0] o, logic [2:0] kind,
                                           logic [63:0] v);
    unique case (kind)
      KindR64: return v;
      KindR32: return {o[63:32], v[31:0]};
      KindR16: return {o[63:16], v[15:0]};
      KindLow: return {o[63:8], v[7:0]};
      default: return {o[63:16], v[7:0], o[7:0]};
    endcase
  endfunction

endpackage

/* rtl/xeu_ctrl.sv */
// Sequencer of the x86 subset execute unit.
// Depends on xeu_pkg; drives xeu_dp through dp_cmd_t.
module xeu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_fire,
  input  logic              clr_done,
  input  xeu_pkg::dp_stat_t stat,
  output xeu_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              res_valid,
  output logic [2:0]        res_status
);
  import xeu_pkg::*;

  typedef enum logic [3:0] {
    SClear, SIdle, SDecode, SMul, SMulDone, SDiv, SPush, SPopTag, SPop,
    SCommit, SOut
  } state_t;

  state_t     state;
  logic [6:0] cnt;

  assign busy = state != SIdle;

  // Commands decoded from state.
  always_comb begin
    cmd.op = CmdNone;
    cmd.idx = cnt[3:0];
    unique case (state)
      SClear:   cmd.op = CmdClear;
      SMul:     cmd.op = CmdMulStep;
      SMulDone: cmd.op = CmdMulDone;
      SDiv:     cmd.op = CmdDivStep;
      SPush, SPopTag, SPop: cmd.op = CmdStkByte;
      SCommit:  cmd.op = CmdCommit;
      default:  cmd.op = (state == SIdle && in_fire) ? CmdLoad : CmdNone;
    endcase
    if (state == SDecode && stat.cmd == OpIdiv && !stat.halted && !stat.illegal &&
        !stat.div_zero)
      cmd.op = CmdDivInit;
  end

  // Advance the sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SClear;
      cnt <= '0;
      res_valid <= 1'b0;
      res_status <= StOk;
    end else begin
      unique case (state)
        SClear: if (clr_done) state <= SIdle;
        SIdle: if (in_fire) begin
          state <= SDecode; cnt <= '0;
        end
        SDecode: begin
          cnt <= '0;
          priority if (stat.halted) begin
            res_status <= StHalt; state <= SOut; res_valid <= 1'b1;
          end else if (stat.illegal) begin
            res_status <= StIll; state <= SOut; res_valid <= 1'b1;
          end else if (stat.cmd == OpIdiv && stat.div_zero) begin
            res_status <= StDiv0; state <= SOut; res_valid <= 1'b1;
          end else if ((stat.cmd == OpPush || stat.cmd == OpPop) && stat.stk_range) begin
            res_status <= StStack; state <= SOut; res_valid <= 1'b1;
          end else begin
            res_status <= StOk;
            priority if (stat.cmd == OpImul) state <= SMul;
            else if (stat.cmd == OpIdiv) state <= SDiv;
            else if (stat.cmd == OpPush) state <= SPush;
            else if (stat.cmd == OpPop) state <= SPopTag;
            else state <= SCommit;
          end
        end
        SMul: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd3) state <= SMulDone;
        end
        SMulDone: state <= SCommit;
        SDiv: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) state <= SCommit;
        end
        SPush: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd8) state <= SCommit;
        end
        SPopTag: begin
          if (stat.tag_bad) begin
            res_status <= StStack; state <= SOut; res_valid <= 1'b1;
          end else begin
            cnt <= 7'd1; state <= SPop;
          end
        end
        SPop: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd9) state <= SCommit;
        end
        SCommit: begin
          state <= SOut; res_valid <= 1'b1;
        end
        default: if (out_fire) begin
          res_valid <= 1'b0; state <= SIdle;
        end
      endcase
    end
  end

endmodule

/* rtl/xeu_dp.sv */
// Datapath of the x86 subset execute unit: register file, stack memory,
// multiplier, divider. Depends on xeu_pkg; driven by xeu_ctrl.
module xeu_dp #(
  parameter int StackBytes = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  xeu_pkg::dp_cmd_t  cmd,
  input  logic [15:0]       prog_len,
  input  logic [4:0]        in_cmd,
  input  logic [2:0]        in_k1,
  input  logic [4:0]        in_n1,
  input  logic [63:0]       in_i1,
  input  logic [2:0]        in_k2,
  input  logic [4:0]        in_n2,
  input  logic [63:0]       in_i2,
  output xeu_pkg::dp_stat_t stat,
  output logic              clr_done,
  output logic [63:0]       rax,
  output logic [63:0]       rdx,
  output logic [63:0]       rfl,
  output logic [63:0]       rip
);
  import xeu_pkg::*;

  localparam int AW = $clog2(StackBytes);
  localparam logic [63:0] Depth = 64'(StackBytes);

  logic [63:0] regs [NumRegs];
  logic [7:0]  mem [StackBytes];
  logic [7:0]  rd_byte;

  // Latched item.
  logic [4:0]  op;
  logic [2:0]  k1, k2;
  logic [4:0]  n1, n2;
  logic [63:0] i1, i2;

  logic [63:0] a, b, sp, acc, q, r, pv;
  logic [AW-1:0] clr_addr;
  logic [63:0] pp;
  logic [1:0]  mi;

  // Operand read; the instruction pointer reads as already advanced.
  logic ok1, ok2, d1;
  logic [63:0] va, vb, r1, r2;
  always_comb begin
    r1 = regs[(n1 < 5'(NumRegs)) ? n1 : 5'd0];
    r2 = regs[(n2 < 5'(NumRegs)) ? n2 : 5'd0];
    if (n1 == RegIp) r1 = r1 + 64'd1;
    if (n2 == RegIp) r2 = r2 + 64'd1;
    d1 = is_reg(k1, n1);
    ok1 = (k1 == KindImm) || d1;
    ok2 = (k2 == KindImm) || is_reg(k2, n2);
    va = (k1 == KindImm) ? i1 : view_get(r1, k1);
    vb = (k2 == KindImm) ? i2 : view_get(r2, k2);
  end

  // Decode status.
  always_comb begin
    stat.cmd = op;
    stat.halted = regs[RegIp] >= {48'd0, prog_len};
    stat.div_zero = va == 64'd0;
    stat.tag_bad = rd_byte != FrameTag;
    stat.stk_range = (op == OpPush) ? (sp < 64'd8 || sp >= Depth)
                                    : (sp > Depth - 64'd10);
    unique case (op)
      OpCdq: stat.illegal = 1'b0;
      OpAdd, OpSub, OpImul, OpCmp: stat.illegal = !(ok1 && ok2);
      OpIdiv: stat.illegal = !ok1;
      OpMov: stat.illegal = !d1 || k2 != KindImm;
      OpMovzx: stat.illegal = !d1 || !ok2;
      OpPush, OpPop: stat.illegal = !d1;
      default: stat.illegal = !(op >= OpSete && op <= OpSetne && d1);
    endcase
  end

  assign sp = regs[RegSp];
  assign clr_done = clr_addr == AW'(StackBytes - 1);

  // Stack address of the current frame byte.
  logic [63:0] saddr;
  always_comb begin
    if (op == OpPush)
      saddr = sp - 64'd8 + {60'd0, cmd.idx};
    else
      saddr = sp + {60'd0, cmd.idx} + 64'd1;
  end

  // Stack memory: write on push and clear, registered read for pop.
  always_ff @(posedge clk) begin
    if (cmd.op == CmdClear)
      mem[clr_addr] <= 8'd0;
    else if (cmd.op == CmdStkByte && op == OpPush)
      mem[saddr[AW-1:0]] <= (cmd.idx == 4'd0) ? FrameTag : pv[8*(cmd.idx-4'd1) +: 8];
    rd_byte <= mem[(cmd.op == CmdLoad) ? AW'(1) : saddr[AW-1:0]];
  end

  // Clear sweep address.
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.op == CmdClear && !clr_done) clr_addr <= clr_addr + AW'(1);
  end

  // One restoring divide step: shift in the next dividend bit, compare.
  logic [64:0] rs;
  logic        q_bit;
  always_comb begin
    rs = {r, q[63]};
    q_bit = rs >= {1'b0, b};
  end

  // Result of the simple ops on commit.
  logic zf, lt, wr_n1;
  logic [63:0] sv, wb, fl_sub, fl_mul, fl_cmp;
  always_comb begin
    zf = regs[RegFl][FlagZf];
    lt = regs[RegFl][FlagSf] ^ regs[RegFl][FlagOf];
    unique case (op)
      OpSete:  sv = {63'd0, zf};
      OpSetl:  sv = {63'd0, lt};
      OpSetle: sv = {63'd0, zf | lt};
      OpSetg:  sv = {63'd0, !zf && !lt};
      OpSetge: sv = {63'd0, !lt};
      default: sv = {63'd0, !zf};
    endcase
    fl_sub = regs[RegFl];
    fl_sub[FlagCf] = b > a;
    fl_sub[FlagZf] = a == b;
    fl_mul = regs[RegFl];
    fl_mul[FlagZf] = acc == 64'd0;
    fl_cmp = regs[RegFl];
    fl_cmp[FlagOf] = b > a;
    fl_cmp[FlagZf] = a == b;
    wb = view_put(r1, k1, sv);
    wr_n1 = op == OpMov || op == OpMovzx || op == OpPop ||
            (op >= OpSete && op <= OpSetne);
  end

  // Register file and datapath work registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= 64'd0;
      regs[RegSp] <= Depth - 64'd1;
    end else begin
      unique case (cmd.op)
        CmdLoad: begin
          op <= in_cmd; k1 <= in_k1; n1 <= in_n1; i1 <= in_i1;
          k2 <= in_k2; n2 <= in_n2; i2 <= in_i2;
        end
        CmdMulStep: begin
          // 64x16 partial product per step
          acc <= ((mi == 2'd0) ? 64'd0 : acc) + (a * {48'd0, b[16*mi +: 16]} << (16 * mi));
          mi <= mi + 2'd1;
        end
        CmdDivInit: begin
          q <= regs[RegAx]; r <= 64'd0; b <= va;
        end
        CmdDivStep: begin
          r <= q_bit ? 64'(rs - {1'b0, b}) : rs[63:0];
          q <= {q[62:0], q_bit};
        end
        CmdStkByte: if (op == OpPop && cmd.idx >= 4'd2)
          pv <= {rd_byte, pv[63:8]};
        CmdCommit: begin
          // an explicit write to the instruction pointer replaces the advance
          if (!(wr_n1 && n1 == RegIp)) regs[RegIp] <= regs[RegIp] + 64'd1;
          unique case (op)
            OpAdd: regs[RegAx] <= a + b;
            OpSub: begin
              regs[RegAx] <= a - b;
              regs[RegFl] <= fl_sub;
            end
            OpImul: begin
              regs[RegAx] <= acc;
              regs[RegFl] <= fl_mul;
            end
            OpCmp: regs[RegFl] <= fl_cmp;
            OpIdiv: begin
              regs[RegAx] <= q; regs[RegDx] <= r;
            end
            OpMov: regs[n1] <= view_put(r1, k1, i2);
            OpMovzx: regs[n1] <= view_put(r1, k1, vb);
            OpPush: regs[RegSp] <= sp - 64'd9;
            OpPop: begin
              if (n1 == RegSp) begin
                regs[RegSp] <= view_put(sp + 64'd9, k1, pv);
              end else begin
                regs[RegSp] <= sp + 64'd9;
                regs[n1] <= view_put(r1, k1, pv);
              end
            end
            OpCdq: ;
            default: regs[n1] <= wb;
          endcase
        end
        default: ;
      endcase
      // Latch operands once decoded.
      if (cmd.op == CmdNone || cmd.op == CmdDivInit) begin
        if (op != OpIdiv || cmd.op == CmdNone) begin
          a <= va;
          if (op != OpIdiv) b <= vb;
        end
        pv <= view_get(r1, k1);
        mi <= 2'd0;
      end
    end
  end

  assign rax = regs[RegAx];
  assign rdx = regs[RegDx];
  assign rfl = regs[RegFl];
  assign rip = regs[RegIp];

endmodule

/* rtl/x86_subset_execute_unit.sv */
// Top level of the x86 subset execute unit.
// Depends on xeu_pkg, xeu_ctrl and xeu_dp.
//
// Channel   Dir  Handshake        Contents
// s_axis    in   tvalid/tready    one decoded instruction
// m_axis    out  tvalid/tready    status and RAX, RDX, RFLAGS, RIP
// cfg       in   cfg_we           program_length
//
// One item at a time. Halted and faulting items go straight to the result
// (a POP with a bad tag after its tag byte is read). Otherwise IMUL runs
// four 64x16 multiply steps, IDIV one quotient bit per cycle in the divider,
// PUSH and POP one stack byte per cycle on the memory port, before the
// commit. The next item is taken once the result has been taken. After
// reset a clearing pass zeros the stack memory byte by byte; no item is
// taken during it. The result holds until taken.
module x86_subset_execute_unit #(
  parameter int STACK_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[4:0], first_kind[7:5], first_reg[12:8], first_imm[76:13],
  // second_kind[79:77], second_reg[84:80], second_imm[148:85]
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], rax_value[66:3], rdx_value[130:67], flags_value[194:131],
  // next_ip[258:195]
  output logic [263:0] m_axis_tdata
);
  import xeu_pkg::*;

  logic [15:0] prog_len;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic busy, clr_done, in_fire, out_fire;
  logic [2:0] status;
  logic [63:0] rax, rdx, rfl, rip;

  // Hold program length.
  always_ff @(posedge clk) begin
    if (rst) prog_len <= 16'd0;
    else if (cfg_we) prog_len <= cfg_wdata;
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {5'd0, rip, rfl, rdx, rax, status};

  xeu_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .clr_done, .stat, .cmd, .busy,
    .res_valid(m_axis_tvalid), .res_status(status)
  );

  xeu_dp #(.StackBytes(STACK_BYTES)) u_dp (
    .clk, .rst, .cmd, .prog_len,
    .in_cmd(s_axis_tdata[4:0]), .in_k1(s_axis_tdata[7:5]),
    .in_n1(s_axis_tdata[12:8]), .in_i1(s_axis_tdata[76:13]),
    .in_k2(s_axis_tdata[79:77]), .in_n2(s_axis_tdata[84:80]),
    .in_i2(s_axis_tdata[148:85]),
    .stat, .clr_done, .rax, .rdx, .rfl, .rip
  );

endmodule
